// File: src/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// shared types and status codes of the iso 8601 timestamp parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

	localparam int ItpQueueDepth = 2;

	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_FORMAT = 3'd1;
	localparam logic [2:0] STAT_NOZONE = 3'd2;
	localparam logic [2:0] STAT_ZRANGE = 3'd3;
	localparam logic [2:0] STAT_DATE   = 3'd4;
	localparam logic [2:0] STAT_TIME   = 3'd5;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} itp_in_t;

	typedef struct packed {
		logic signed [38:0] unix_seconds;
		logic [2:0]         status;
	} itp_out_t;

	typedef struct packed {
		logic [2:0]  pre_status;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [6:0]  zone_hours;
		logic [6:0]  zone_minutes;
		logic        zone_negative;
		logic        use_offset;
	} itp_rec_t;

endpackage

`default_nettype wire

// File: src/iso8601_timestamp_parser.sv
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser
// iso 8601 text to unix seconds with zone offset removed
//
// char channel: one text byte per request, last_char set on the final byte.
// the parser takes a byte every cycle while the string queue has room.
// time channel: one request per string, unix_seconds and status, zero
// seconds on any error.
// path: the string of the final byte passes the queue, the seven steps of the date
// unit (check, valid, yoe, doe, days, secs, sum) and one output register.
// throughput: bytes at one per cycle while the queue has room; strings one at a
// time, set by the sequential date unit; shorter strings back up in the queue.
// a stalled receiver holds the result in the output register while the
// queue and then the parser fill and drop char_ready.
// reset clears the parser to the start of a string, empties the queue and
// drops time_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iso8601_timestamp_parser #(
	parameter int QUEUE_DEPTH = itp_pkg::ItpQueueDepth
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               char_valid,
	output logic              char_ready,
	input  itp_pkg::itp_in_t  char_data,
	output logic              time_valid,
	input  wire               time_ready,
	output itp_pkg::itp_out_t time_data
);
	import itp_pkg::*;

	logic     rec_push, rec_full, rec_pop, rec_empty;
	itp_rec_t rec_wr, rec_rd;

	itp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.rec_push   (rec_push),
		.rec_full   (rec_full),
		.rec_data   (rec_wr)
	);

	itp_fifo #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec_wr),
		.full      (rec_full),
		.pop       (rec_pop),
		.pop_data  (rec_rd),
		.empty     (rec_empty)
	);

	itp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_empty  (rec_empty),
		.rec_pop    (rec_pop),
		.rec_data   (rec_rd),
		.time_valid (time_valid),
		.time_ready (time_ready),
		.time_data  (time_data)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		time_valid && (time_data.status != STAT_OK) |-> time_data.unix_seconds == '0)
		else $error("error result carries nonzero seconds");

	assert property (@(posedge clk) disable iff (!arst_n)
		time_valid && (time_data.status == STAT_OK)
		|-> (time_data.unix_seconds >= -39'sd62135683140)
			&& (time_data.unix_seconds <= 39'sd253402387139))
		else $error("seconds outside the four digit year range");

	assert property (@(posedge clk) disable iff (!arst_n)
		time_valid |-> time_data.status <= STAT_TIME)
		else $error("undefined status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |=> !rec_empty)
		else $error("pushed string lost from queue");

endmodule

`default_nettype wire

// File: src/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// byte parser: walks the timestamp text and hands each finished string on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              char_valid,
	output logic             char_ready,
	input  itp_pkg::itp_in_t char_data,
	output logic             rec_push,
	input  wire              rec_full,
	output itp_pkg::itp_rec_t rec_data
);
	import itp_pkg::*;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Z     = 8'h5A;

	typedef enum logic [5:0] {
		SEC_PREFIX = 6'b000001,
		SEC_AFTER  = 6'b000010,
		SEC_FRAC0  = 6'b000100,
		SEC_FRACN  = 6'b001000,
		SEC_ZULU   = 6'b010000,
		SEC_OFFSET = 6'b100000
	} section_t;

	function automatic logic [6:0] acc7(input logic [6:0] f, input logic [3:0] d);
		logic [10:0] t;
		t = {1'b0, f, 3'b000} + {3'b000, f, 1'b0} + {7'b0, d};
		return t[6:0];
	endfunction

	function automatic logic [13:0] acc14(input logic [13:0] f, input logic [3:0] d);
		logic [17:0] t;
		t = {1'b0, f, 3'b000} + {3'b000, f, 1'b0} + {14'b0, d};
		return t[13:0];
	endfunction

	section_t    sec_q, sec_n;
	logic [4:0]  pos_q, pos_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  month_q, month_n, day_q, day_n;
	logic [6:0]  hour_q, hour_n, minute_q, minute_n, second_q, second_n;
	logic [6:0]  zh_q, zh_n, zm_q, zm_n;
	logic        zneg_q, zneg_n;
	logic [2:0]  err_q, err_n;
	logic [2:0]  pre_status;
	logic        is_dig, zone_go, accept;
	logic [7:0]  dig8;
	logic [3:0]  d4;

	assign char_ready = !rec_full;
	assign accept     = char_valid && char_ready;
	assign rec_push   = accept && char_data.last_char;
	assign is_dig     = (char_data.char_code >= CH_ZERO) && (char_data.char_code <= CH_NINE);
	assign dig8       = char_data.char_code - CH_ZERO;
	assign d4         = dig8[3:0];

	always_comb begin
		sec_n    = sec_q;
		pos_n    = pos_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		zh_n     = zh_q;
		zm_n     = zm_q;
		zneg_n   = zneg_q;
		err_n    = err_q;
		zone_go  = 1'b0;
		if (err_q == STAT_OK) begin
			unique case (sec_q)
				SEC_PREFIX: begin
					if (pos_q == 5'd4 || pos_q == 5'd7) begin
						if (char_data.char_code != CH_DASH) err_n = STAT_FORMAT;
					end else if (pos_q == 5'd10) begin
						if (char_data.char_code != CH_T && char_data.char_code != CH_SPACE)
							err_n = STAT_FORMAT;
					end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
						if (char_data.char_code != CH_COLON) err_n = STAT_FORMAT;
					end else if (!is_dig) begin
						err_n = STAT_FORMAT;
					end else if (pos_q <= 5'd3) begin
						year_n = acc14(year_q, d4);
					end else if (pos_q <= 5'd6) begin
						month_n = acc7(month_q, d4);
					end else if (pos_q <= 5'd9) begin
						day_n = acc7(day_q, d4);
					end else if (pos_q <= 5'd12) begin
						hour_n = acc7(hour_q, d4);
					end else if (pos_q <= 5'd15) begin
						minute_n = acc7(minute_q, d4);
					end else begin
						second_n = acc7(second_q, d4);
					end
					if (pos_q >= 5'd18) sec_n = SEC_AFTER;
					else pos_n = pos_q + 5'd1;
				end
				SEC_AFTER: begin
					if (char_data.char_code == CH_DOT) sec_n = SEC_FRAC0;
					else zone_go = 1'b1;
				end
				SEC_FRAC0: begin
					if (is_dig) sec_n = SEC_FRACN;
					else err_n = STAT_FORMAT;
				end
				SEC_FRACN: begin
					if (!is_dig) zone_go = 1'b1;
				end
				SEC_ZULU: begin
					err_n = STAT_FORMAT;
				end
				SEC_OFFSET: begin
					if (pos_q >= 5'd5) begin
						err_n = STAT_FORMAT;
					end else begin
						if (pos_q == 5'd2) begin
							if (char_data.char_code != CH_COLON) err_n = STAT_FORMAT;
						end else if (!is_dig) begin
							err_n = STAT_FORMAT;
						end else if (pos_q < 5'd2) begin
							zh_n = acc7(zh_q, d4);
						end else begin
							zm_n = acc7(zm_q, d4);
						end
						pos_n = pos_q + 5'd1;
					end
				end
				default: begin
					err_n = STAT_FORMAT;
				end
			endcase
			if (zone_go) begin
				if (char_data.char_code == CH_Z) begin
					sec_n = SEC_ZULU;
				end else if (char_data.char_code == CH_PLUS || char_data.char_code == CH_DASH) begin
					sec_n  = SEC_OFFSET;
					zneg_n = (char_data.char_code == CH_DASH);
					pos_n  = 5'd0;
				end else begin
					err_n = STAT_NOZONE;
				end
			end
		end
	end

	always_comb begin
		if (err_n != STAT_OK) begin
			pre_status = err_n;
		end else begin
			unique case (sec_n) inside
				SEC_PREFIX, SEC_FRAC0: pre_status = STAT_FORMAT;
				SEC_AFTER, SEC_FRACN:  pre_status = STAT_NOZONE;
				SEC_ZULU:              pre_status = STAT_OK;
				SEC_OFFSET: begin
					if (pos_n != 5'd5) pre_status = STAT_FORMAT;
					else if (zh_n > 7'd23 || zm_n > 7'd59) pre_status = STAT_ZRANGE;
					else pre_status = STAT_OK;
				end
				default: pre_status = STAT_FORMAT;
			endcase
		end
	end

	always_comb begin
		rec_data.pre_status    = pre_status;
		rec_data.year          = year_n;
		rec_data.month         = month_n;
		rec_data.day           = day_n;
		rec_data.hour          = hour_n;
		rec_data.minute        = minute_n;
		rec_data.second        = second_n;
		rec_data.zone_hours    = zh_n;
		rec_data.zone_minutes  = zm_n;
		rec_data.zone_negative = zneg_n;
		rec_data.use_offset    = (sec_n == SEC_OFFSET);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q    <= SEC_PREFIX;
			pos_q    <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			zh_q     <= '0;
			zm_q     <= '0;
			zneg_q   <= 1'b0;
			err_q    <= STAT_OK;
		end else if (accept) begin
			if (char_data.last_char) begin
				sec_q    <= SEC_PREFIX;
				pos_q    <= '0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				zh_q     <= '0;
				zm_q     <= '0;
				zneg_q   <= 1'b0;
				err_q    <= STAT_OK;
			end else begin
				sec_q    <= sec_n;
				pos_q    <= pos_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				zh_q     <= zh_n;
				zm_q     <= zm_n;
				zneg_q   <= zneg_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/itp_fifo.sv
// ----------------------------------------------------------------------------
// itp_fifo
// short queue of parsed strings between the byte parser and the date unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_fifo #(
	parameter int QUEUE_DEPTH = itp_pkg::ItpQueueDepth
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  itp_pkg::itp_rec_t push_data,
	output logic              full,
	input  wire               pop,
	output itp_pkg::itp_rec_t pop_data,
	output logic              empty
);
	import itp_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

	itp_rec_t        mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntFull);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: src/itp_back.sv
// ----------------------------------------------------------------------------
// itp_back
// date and time check, civil day count and second sum, one string at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               rec_empty,
	output logic              rec_pop,
	input  itp_pkg::itp_rec_t rec_data,
	output logic              time_valid,
	input  wire               time_ready,
	output itp_pkg::itp_out_t time_data
);
	import itp_pkg::*;

	localparam logic [22:0] Recip25 = 23'd1311;

	typedef enum logic [8:0] {
		BK_IDLE  = 9'b000000001,
		BK_CHECK = 9'b000000010,
		BK_VALID = 9'b000000100,
		BK_YOE   = 9'b000001000,
		BK_DOE   = 9'b000010000,
		BK_DAYS  = 9'b000100000,
		BK_SECS  = 9'b001000000,
		BK_SUM   = 9'b010000000,
		BK_DONE  = 9'b100000000
	} back_state_t;

	// exact x / 25 for x below 4096
	function automatic logic [7:0] div25(input logic [11:0] x);
		logic [22:0] p;
		p = {11'b0, x} * Recip25;
		return p[22:15];
	endfunction

	// days from march 1 to the first of the month
	function automatic logic [8:0] march_base(input logic [6:0] m);
		logic [8:0] b;
		case (m)
			7'd3:    b = 9'd0;
			7'd4:    b = 9'd31;
			7'd5:    b = 9'd61;
			7'd6:    b = 9'd92;
			7'd7:    b = 9'd122;
			7'd8:    b = 9'd153;
			7'd9:    b = 9'd184;
			7'd10:   b = 9'd214;
			7'd11:   b = 9'd245;
			7'd12:   b = 9'd275;
			7'd1:    b = 9'd306;
			7'd2:    b = 9'd337;
			default: b = 9'd0;
		endcase
		return b;
	endfunction

	function automatic logic [6:0] month_days(input logic [6:0] m, input logic leap);
		logic [6:0] n;
		case (m) inside
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 7'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    n = 7'd30;
			7'd2:                                       n = leap ? 7'd29 : 7'd28;
			default:                                    n = 7'd0;
		endcase
		return n;
	endfunction

	back_state_t        state_q;
	itp_rec_t           rec_q;
	logic [7:0]         q100_q;
	logic [13:0]        yy_q;
	logic [16:0]        tod_q, off_q;
	logic [8:0]         doy_q;
	logic [2:0]         status_q;
	logic [4:0]         era_q;
	logic [8:0]         yoe_q;
	logic [17:0]        doe_q;
	logic [21:0]        era_days_q;
	logic signed [22:0] days_q;
	logic signed [39:0] dsec_q;
	logic signed [38:0] secs_q;
	itp_out_t           out_q;
	logic               out_valid_q;

	logic               leap, date_bad, time_bad, out_load;
	logic [6:0]         dim;
	logic [13:0]        yy_n, q100_x100, era_x400, yoe_wide;
	logic [7:0]         q100_n, era_wide, c100;
	logic [2:0]         status_n;
	logic signed [39:0] days_ext, tod_ext, off_ext, secs_n;

	assign rec_pop    = (state_q == BK_IDLE) && !rec_empty;
	assign out_load   = (state_q == BK_DONE) && (!out_valid_q || time_ready);
	assign time_valid = out_valid_q;
	assign time_data  = out_q;

	assign yy_n      = rec_q.year - {13'b0, (rec_q.month <= 7'd2)};
	assign q100_n    = div25(rec_q.year[13:2]);
	assign q100_x100 = {6'b0, q100_q} * 14'd100;
	assign leap      = (rec_q.year[1:0] == 2'b00)
		&& ((rec_q.year != q100_x100) || (q100_q[1:0] == 2'b00));
	assign dim       = month_days(rec_q.month, leap);
	assign date_bad  = (rec_q.year == '0) || (rec_q.month == '0) || (rec_q.month > 7'd12)
		|| (rec_q.day == '0) || (rec_q.day > dim);
	assign time_bad  = (rec_q.hour > 7'd23) || (rec_q.minute > 7'd59) || (rec_q.second > 7'd59);
	assign era_wide  = div25({2'b0, yy_q[13:4]});
	assign era_x400  = {9'b0, era_q} * 14'd400;
	assign yoe_wide  = yy_q - era_x400;
	assign c100      = div25({5'b0, yoe_q[8:2]});
	assign days_ext  = $signed({{17{days_q[22]}}, days_q});
	assign tod_ext   = $signed({23'b0, tod_q});
	assign off_ext   = $signed({23'b0, off_q});

	always_comb begin
		if (rec_q.pre_status != STAT_OK) status_n = rec_q.pre_status;
		else if (date_bad) status_n = STAT_DATE;
		else if (time_bad) status_n = STAT_TIME;
		else status_n = STAT_OK;
	end

	always_comb begin
		secs_n = dsec_q + tod_ext;
		if (rec_q.use_offset) begin
			if (rec_q.zone_negative) secs_n = dsec_q + tod_ext + off_ext;
			else secs_n = dsec_q + tod_ext - off_ext;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (rec_pop) rec_q <= rec_data;
			end
			BK_CHECK: begin
				q100_q <= q100_n;
				yy_q   <= yy_n;
				tod_q  <= {10'b0, rec_q.hour} * 17'd3600 + {10'b0, rec_q.minute} * 17'd60
					+ {10'b0, rec_q.second};
				off_q  <= {10'b0, rec_q.zone_hours} * 17'd3600
					+ {10'b0, rec_q.zone_minutes} * 17'd60;
				doy_q  <= march_base(rec_q.month) + {2'b0, rec_q.day} - 9'd1;
			end
			BK_VALID: begin
				status_q <= status_n;
				era_q    <= era_wide[4:0];
			end
			BK_YOE: begin
				yoe_q <= yoe_wide[8:0];
			end
			BK_DOE: begin
				doe_q      <= {9'b0, yoe_q} * 18'd365 + {11'b0, yoe_q[8:2]} - {10'b0, c100}
					+ {9'b0, doy_q};
				era_days_q <= {17'b0, era_q} * 22'd146097;
			end
			BK_DAYS: begin
				days_q <= $signed({1'b0, era_days_q}) + $signed({5'b0, doe_q}) - 23'sd719468;
			end
			BK_SECS: begin
				dsec_q <= days_ext * 40'sd86400;
			end
			BK_SUM: begin
				secs_q <= secs_n[38:0];
			end
			BK_DONE: begin
				if (out_load) begin
					out_q.status       <= status_q;
					out_q.unix_seconds <= (status_q == STAT_OK) ? secs_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (time_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				BK_IDLE:  if (rec_pop) state_q <= BK_CHECK;
				BK_CHECK: state_q <= BK_VALID;
				BK_VALID: state_q <= BK_YOE;
				BK_YOE:   state_q <= BK_DOE;
				BK_DOE:   state_q <= BK_DAYS;
				BK_DAYS:  state_q <= BK_SECS;
				BK_SECS:  state_q <= BK_SUM;
				BK_SUM:   state_q <= BK_DONE;
				BK_DONE:  if (out_load) state_q <= BK_IDLE;
				default:  state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
